@@ rtl/pto_pkg.sv @@
// Shared types and constants of the probability threshold overlay.
package pto_pkg;

  // Field widths.
  localparam int unsigned PROB_W = 17;
  localparam int unsigned PIX_W  = 8;

  // log2(100) in Q24, rounded, and the width of the probability times it.
  localparam int unsigned          LOG_W        = 27;
  localparam logic [LOG_W-1:0]     LOG2_100_Q24 = 27'd111465410;
  localparam int unsigned          PROD_W       = PROB_W + LOG_W;

  // Remainder width of the long division: a divisor in use is at most 2^16.
  localparam int unsigned REM_W = 16;

  // Full-scale threshold, 1.0 in Q1.16.
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

  // Table of 2^(-k/16) in Q1.16 for k = 0 .. 16.
  localparam int unsigned TAB_W  = 17;
  localparam int unsigned DIFF_W = 12;
  localparam logic [TAB_W-1:0] POW2_NEG_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  // Per-pixel information that travels beside the arithmetic.
  typedef struct packed {
    logic             mask;  // pixel lies inside the mask
    logic             chg;   // masked in and probability at or below threshold
    logic             full;  // threshold at or above 1.0
    logic             pz;    // probability is zero
    logic             ovf;   // exponent integer part is 8 or more
    logic [PIX_W-1:0] gray;
  } pto_side_t;

endpackage

@@ rtl/pto_front.sv @@
// Front end: input capture, probability times log2(100), and division setup.
module pto_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [pto_pkg::PROB_W-1:0] in_probability,
  input  logic                       in_mask_valid,
  input  logic [pto_pkg::PIX_W-1:0]  in_gray_level,
  input  logic [pto_pkg::PROB_W-1:0] thr,
  input  logic [pto_pkg::PROB_W-1:0] dvs,
  output logic                       out_vld,
  output pto_pkg::pto_side_t         out_side,
  output logic [pto_pkg::REM_W-1:0]  out_rem,
  output logic [FRAC_BITS+2:0]       out_nq
);

  localparam int unsigned QW = FRAC_BITS + 3;
  localparam int unsigned SH = 24 - FRAC_BITS;
  localparam int unsigned PW = pto_pkg::PROD_W;
  localparam int unsigned LW = pto_pkg::LOG_W;

  logic                 s1_vld_r;
  logic [PW-1:0]        prod_r;
  pto_pkg::pto_side_t   s1_side_r;
  pto_pkg::pto_side_t   side_nxt;
  pto_pkg::pto_side_t   s2_side_nxt;
  logic                 vld_r;
  pto_pkg::pto_side_t   side_r;
  logic [pto_pkg::REM_W-1:0] rem_r;
  logic [QW-1:0]        nq_r;

  // Flags known at the input beat.
  always_comb begin
    side_nxt      = '0;
    side_nxt.mask = in_mask_valid;
    side_nxt.chg  = in_mask_valid && (in_probability <= thr);
    side_nxt.full = (thr >= pto_pkg::ONE_Q16);
    side_nxt.pz   = (in_probability == '0);
    side_nxt.gray = in_gray_level;
  end

  // Valid bits of the two front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
      vld_r    <= s1_vld_r;
    end
  end

  // Stage one: the product p * log2(100).
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r    <= PW'(in_probability) * PW'(pto_pkg::LOG2_100_Q24);
      s1_side_r <= side_nxt;
    end
  end

  // An exponent of 8 or more shows as a high product part at or above the divisor.
  always_comb begin
    s2_side_nxt     = s1_side_r;
    s2_side_nxt.ovf = (prod_r[PW-1:LW] >= dvs);
  end

  // Stage two: the high product bits seed the remainder and the low bits
  // are the dividend bits still to come.
  always_ff @(posedge clk) begin
    side_r <= s2_side_nxt;
    rem_r  <= prod_r[LW+pto_pkg::REM_W-1:LW];
    nq_r   <= prod_r[LW-1:SH];
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_rem  = rem_r;
  assign out_nq   = nq_r;

endmodule

@@ rtl/pto_div_stage.sv @@
// One restoring division step: one quotient bit per pipeline stage.
module pto_div_stage #(
  parameter int unsigned QW = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  pto_pkg::pto_side_t         in_side,
  input  logic [pto_pkg::REM_W-1:0]  in_rem,
  input  logic [QW-1:0]              in_nq,
  input  logic [pto_pkg::PROB_W-1:0] dvs,
  output logic                       out_vld,
  output pto_pkg::pto_side_t         out_side,
  output logic [pto_pkg::REM_W-1:0]  out_rem,
  output logic [QW-1:0]              out_nq
);

  localparam int unsigned RW = pto_pkg::REM_W;

  logic                 vld_r;
  pto_pkg::pto_side_t   side_r;
  logic [RW-1:0]        rem_r;
  logic [QW-1:0]        nq_r;
  logic [RW:0]          sh;
  logic                 ge;
  logic [RW-1:0]        rem_nxt;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    sh      = {in_rem, in_nq[QW-1]};
    ge      = (sh >= dvs);
    rem_nxt = ge ? RW'(sh - dvs) : RW'(sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Dividend bits shift out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    side_r <= in_side;
    rem_r  <= rem_nxt;
    nq_r   <= {in_nq[QW-2:0], ge};
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_rem  = rem_r;
  assign out_nq   = nq_r;

endmodule

@@ rtl/pto_back.sv @@
// Back end: table interpolation of 2^-r, scaling by 255 and output select.
module pto_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  pto_pkg::pto_side_t        in_side,
  input  logic [FRAC_BITS+2:0]      in_q,
  output logic                      out_strobe,
  output logic [pto_pkg::PIX_W-1:0] out_binary_red,
  output logic [pto_pkg::PIX_W-1:0] out_mapped_red,
  output logic [pto_pkg::PIX_W-1:0] out_green_level,
  output logic [pto_pkg::PIX_W-1:0] out_blue_level,
  output logic                      out_is_change
);

  localparam int unsigned QW  = FRAC_BITS + 3;
  localparam int unsigned RMW = FRAC_BITS - 4;
  localparam int unsigned TW  = pto_pkg::TAB_W;
  localparam int unsigned DW  = pto_pkg::DIFF_W;
  localparam int unsigned MW  = DW + RMW;
  localparam int unsigned SW  = TW + 8;
  localparam int unsigned XW  = pto_pkg::PIX_W;

  logic [3:0]           idx;
  logic [RMW-1:0]       rm;
  logic [TW-1:0]        hi;
  logic [TW-1:0]        lo;
  logic [DW-1:0]        diff;
  logic                 b1_vld_r;
  pto_pkg::pto_side_t   b1_side_r;
  logic [TW-1:0]        hi_r;
  logic [2:0]           n_r;
  logic [MW-1:0]        ip_r;
  logic [TW-1:0]        t;
  logic [SW-1:0]        scaled;
  logic [SW-1:0]        shifted;
  logic [XW-1:0]        map_val;
  logic [XW-1:0]        bred_nxt;
  logic [XW-1:0]        mred_nxt;
  logic [XW-1:0]        gray_nxt;
  logic                 strobe_r;
  logic [XW-1:0]        bred_r;
  logic [XW-1:0]        mred_r;
  logic [XW-1:0]        green_r;
  logic [XW-1:0]        blue_r;
  logic                 chg_r;

  // Table neighbors around the top four fraction bits.
  always_comb begin
    idx  = in_q[FRAC_BITS-1:FRAC_BITS-4];
    rm   = in_q[RMW-1:0];
    hi   = pto_pkg::POW2_NEG_TAB[5'(idx)];
    lo   = pto_pkg::POW2_NEG_TAB[5'(idx) + 5'd1];
    diff = DW'(hi - lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      b1_vld_r <= in_vld;
      strobe_r <= b1_vld_r;
    end
  end

  // Stage one: the interpolation product.
  always_ff @(posedge clk) begin
    b1_side_r <= in_side;
    hi_r      <= hi;
    n_r       <= in_q[QW-1:QW-3];
    ip_r      <= MW'(diff) * MW'(rm);
  end

  // Stage two: 255 * t shifted down by 16 + n, then the output selection.
  always_comb begin
    t       = hi_r - TW'(ip_r >> RMW);
    scaled  = {t, 8'd0} - SW'(t);
    shifted = scaled >> n_r;
    if (b1_side_r.full) begin
      map_val = b1_side_r.pz ? 8'hFF : 8'h00;
    end else if (b1_side_r.ovf) begin
      map_val = 8'h00;
    end else begin
      map_val = shifted[23:16];
    end
    gray_nxt = b1_side_r.mask ? b1_side_r.gray : 8'h00;
    bred_nxt = b1_side_r.chg ? 8'hFF : gray_nxt;
    mred_nxt = b1_side_r.chg ? map_val : gray_nxt;
  end

  always_ff @(posedge clk) begin
    bred_r  <= bred_nxt;
    mred_r  <= mred_nxt;
    green_r <= gray_nxt;
    blue_r  <= gray_nxt;
    chg_r   <= b1_side_r.chg;
  end

  assign out_strobe      = strobe_r;
  assign out_binary_red  = bred_r;
  assign out_mapped_red  = mred_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;
  assign out_is_change   = chg_r;

endmodule

@@ rtl/prob_threshold_overlay.sv @@
// Top level of the probability threshold overlay pipeline.
//
// One pixel beat enters when start is high and busy is low: a Q1.16
// probability, a mask bit and a gray byte. Each beat gives exactly one
// result beat, shown for one cycle with out_strobe high; the receiver
// cannot stall, so the pipeline never holds.
// Each pixel passes the front stages, the division chain and the back
// stages; the long division of p * log2(100) by (1 - threshold) costs
// one stage per quotient bit. Throughput is one pixel per cycle, back to
// back. The threshold is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while no pixel is in flight, which the block
// does not enforce. Reset sets the threshold to 0.5 and empties the
// pipeline; busy stays high during reset and for one cycle after it.
module prob_threshold_overlay #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pto_pkg::PROB_W-1:0] in_probability,
  input  logic                       in_mask_valid,
  input  logic [pto_pkg::PIX_W-1:0]  in_gray_level,
  input  logic                       cfg_wr_en,
  input  logic [pto_pkg::PROB_W-1:0] cfg_wr_data,
  output logic                       out_strobe,
  output logic [pto_pkg::PIX_W-1:0]  out_binary_red,
  output logic [pto_pkg::PIX_W-1:0]  out_mapped_red,
  output logic [pto_pkg::PIX_W-1:0]  out_green_level,
  output logic [pto_pkg::PIX_W-1:0]  out_blue_level,
  output logic                       out_is_change
);

  localparam int unsigned QW  = FRAC_BITS + 3;
  localparam int unsigned LAT = QW + 4;
  localparam int unsigned PW  = pto_pkg::PROB_W;
  localparam int unsigned RW  = pto_pkg::REM_W;

  logic                 busy_r;
  logic                 in_fire;
  logic [PW-1:0]        thr_r;
  logic [PW-1:0]        dvs_r;
  logic [PW-1:0]        dvs_nxt;

  logic                 dv_vld  [QW+1];
  pto_pkg::pto_side_t   dv_side [QW+1];
  logic [RW-1:0]        dv_rem  [QW+1];
  logic [QW-1:0]        dv_nq   [QW+1];

  assign busy    = busy_r || !rst_n;
  assign in_fire = start && !busy;

  // Busy covers reset and the first cycle after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Threshold register and the divisor 1 - threshold; at or above 1.0 the divisor
  // is unused since the full-scale limit applies.
  assign dvs_nxt = PW'(18'(pto_pkg::ONE_Q16) - 18'(cfg_wr_data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 17'd32768;
      dvs_r <= 17'd32768;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
      dvs_r <= dvs_nxt;
    end
  end

  pto_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_probability (in_probability),
    .in_mask_valid  (in_mask_valid),
    .in_gray_level  (in_gray_level),
    .thr            (thr_r),
    .dvs            (dvs_r),
    .out_vld        (dv_vld[0]),
    .out_side       (dv_side[0]),
    .out_rem        (dv_rem[0]),
    .out_nq         (dv_nq[0])
  );

  // Division chain: one stage per quotient bit.
  for (genvar i = 0; i < QW; i++) begin : g_div
    pto_div_stage #(
      .QW (QW)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[i]),
      .in_side  (dv_side[i]),
      .in_rem   (dv_rem[i]),
      .in_nq    (dv_nq[i]),
      .dvs      (dvs_r),
      .out_vld  (dv_vld[i+1]),
      .out_side (dv_side[i+1]),
      .out_rem  (dv_rem[i+1]),
      .out_nq   (dv_nq[i+1])
    );
  end

  pto_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (dv_vld[QW]),
    .in_side         (dv_side[QW]),
    .in_q            (dv_nq[QW]),
    .out_strobe      (out_strobe),
    .out_binary_red  (out_binary_red),
    .out_mapped_red  (out_mapped_red),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_is_change   (out_is_change)
  );

  // The final remainder is not needed.
  logic unused_rem;
  assign unused_rem = ^dv_rem[QW];

`ifndef SYNTHESIS
  // Every accepted beat comes out as exactly one result strobe, and no strobe comes without one.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(in_fire, LAT))
    else $error("result strobe does not match an accepted beat");

  // A pixel that is not a change pixel carries gray or zero on all colors.
  a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_change |->
      out_binary_red == out_green_level && out_mapped_red == out_green_level &&
      out_blue_level == out_green_level)
    else $error("colors differ on a pixel that is not a change pixel");

  // A change pixel has full binary red and matching green and blue.
  a_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_change |->
      out_binary_red == 8'hFF && out_blue_level == out_green_level)
    else $error("change pixel with wrong binary red or green and blue");

  // Busy drops once reset has been gone for a cycle.
  a_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy high outside reset");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the probability threshold overlay pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROB_W       = pto_pkg::PROB_W;
  localparam int unsigned PIX_W        = pto_pkg::PIX_W;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned LATENCY      = FRAC_BITS + 7;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned FULL_SCALE   = 65536;
  localparam int unsigned PROB_MAX     = 131071;
  localparam int unsigned PHASE_ITEMS  = 55;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned MAX_GAP      = 12;
  localparam logic [63:0] LOG2_100     = 64'd111465410;

  // One expected result beat, with the probability that caused it.
  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [PIX_W-1:0]  binary_red;
    logic [PIX_W-1:0]  mapped_red;
    logic [PIX_W-1:0]  green_level;
    logic [PIX_W-1:0]  blue_level;
    logic              is_change;
  } overlay_px_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [PROB_W-1:0] in_probability;
  logic              in_mask_valid;
  logic [PIX_W-1:0]  in_gray_level;
  logic              cfg_wr_en;
  logic [PROB_W-1:0] cfg_wr_data;
  logic              out_strobe;
  logic [PIX_W-1:0]  out_binary_red;
  logic [PIX_W-1:0]  out_mapped_red;
  logic [PIX_W-1:0]  out_green_level;
  logic [PIX_W-1:0]  out_blue_level;
  logic              out_is_change;

  overlay_px_t       pending_pixels[$];
  logic [PROB_W-1:0] threshold_q;
  int unsigned       fail_count  = 0;
  int unsigned       cycle_count = 0;

  prob_threshold_overlay #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_probability  (in_probability),
    .in_mask_valid   (in_mask_valid),
    .in_gray_level   (in_gray_level),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_strobe      (out_strobe),
    .out_binary_red  (out_binary_red),
    .out_mapped_red  (out_mapped_red),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_is_change   (out_is_change)
  );

  always #10 clk = ~clk;

  // 2^(-k/16) in Q1.16 for k = 0 .. 16.
  function automatic logic [31:0] exp2_neg(int unsigned k);
    case (k)
      0:  return 32'd65536;
      1:  return 32'd62757;
      2:  return 32'd60097;
      3:  return 32'd57549;
      4:  return 32'd55109;
      5:  return 32'd52773;
      6:  return 32'd50535;
      7:  return 32'd48393;
      8:  return 32'd46341;
      9:  return 32'd44376;
      10: return 32'd42495;
      11: return 32'd40693;
      12: return 32'd38968;
      13: return 32'd37316;
      14: return 32'd35734;
      15: return 32'd34219;
      default: return 32'd32768;
    endcase
  endfunction

  // Graded red of a change pixel: 255 * 2^-(p * log2(100) / (1 - thr)).
  function automatic logic [PIX_W-1:0] graded_red(logic [PROB_W-1:0] p,
                                                  logic [PROB_W-1:0] thr);
    logic [63:0] quo;
    logic [63:0] expo;
    int unsigned n;
    int unsigned idx;
    int unsigned rem;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] t;
    // At full scale the limit of the curve is used.
    if (thr >= FULL_SCALE)
      return (p == 0) ? 8'd255 : 8'd0;
    quo  = (64'(p) * LOG2_100) / (64'(FULL_SCALE) - 64'(thr));
    expo = quo >> (24 - FRAC_BITS);
    if ((expo >> FRAC_BITS) >= 64'd8)
      return 8'd0;
    n   = 32'(expo >> FRAC_BITS);
    idx = 32'((expo >> (FRAC_BITS - 4)) & 64'hF);
    rem = 32'(expo & ((64'd1 << (FRAC_BITS - 4)) - 64'd1));
    hi  = exp2_neg(idx);
    lo  = exp2_neg(idx + 1);
    t   = hi - (((hi - lo) * rem) >> (FRAC_BITS - 4));
    return 8'((32'd255 * t) >> (16 + n));
  endfunction

  // Full result beat for one pixel under the given threshold.
  function automatic overlay_px_t predict_overlay(logic [PROB_W-1:0] p, logic m,
                                                  logic [PIX_W-1:0] g,
                                                  logic [PROB_W-1:0] thr);
    overlay_px_t px;
    px = '0;
    px.prob = p;
    if (m) begin
      px.binary_red  = g;
      px.mapped_red  = g;
      px.green_level = g;
      px.blue_level  = g;
      if (p <= thr) begin
        px.binary_red = 8'd255;
        px.mapped_red = graded_red(p, thr);
        px.is_change  = 1'b1;
      end
    end
    return px;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int got, int want, int p);
    if (got != want)
      report_error($sformatf("p=%0d thr=%0d %s: got %0d, expected %0d",
                             p, threshold_q, name, got, want));
  endtask

  // Every strobed result beat is compared with the oldest pending pixel.
  always @(posedge clk) begin
    overlay_px_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_error("result beat with no pixel pending");
      end else begin
        want = pending_pixels.pop_front();
        check_field("binary_red", out_binary_red, want.binary_red, want.prob);
        check_field("mapped_red", out_mapped_red, want.mapped_red, want.prob);
        check_field("green_level", out_green_level, want.green_level, want.prob);
        check_field("blue_level", out_blue_level, want.blue_level, want.prob);
        check_field("is_change", out_is_change, want.is_change, want.prob);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one pixel beat and return at the edge that accepts it; start stays high.
  task automatic send_pixel(logic [PROB_W-1:0] p, logic m, logic [PIX_W-1:0] g);
    in_probability <= p;
    in_mask_valid  <= m;
    in_gray_level  <= g;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_pixels.push_back(predict_overlay(p, m, g, threshold_q));
  endtask

  // Random sender gap: each cycle is idle with the given percentage.
  task automatic idle_gap(int unsigned pct);
    int unsigned n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender off until every pending pixel has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    @(posedge clk);
  endtask

  // Threshold writes happen only with the pipeline empty.
  task automatic load_threshold(logic [PROB_W-1:0] v);
    wait_for_results();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold_q = v;
  endtask

  // Probability mix: mostly change pixels, with the graded range and the edges.
  function automatic logic [PROB_W-1:0] pick_probability(logic [PROB_W-1:0] thr);
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(99);
    if (sel < 35)
      return PROB_W'($urandom_range(thr, 0));
    if (sel < 50)
      return PROB_W'($urandom_range(FULL_SCALE, 0));
    if (sel < 65)
      return PROB_W'($urandom_range(PROB_MAX, 0));
    if (sel < 80) begin
      case ($urandom_range(4))
        0:       return '0;
        1:       return thr;
        2:       return thr + 1'b1;
        3:       return PROB_W'(FULL_SCALE);
        default: return PROB_W'(PROB_MAX);
      endcase
    end
    // Region where the graded red is nonzero, and a little beyond it.
    span = (thr >= FULL_SCALE) ? 0 : ((FULL_SCALE - thr) * 5) / 4;
    if (span > thr) span = thr;
    return PROB_W'($urandom_range(span, 0));
  endfunction

  // Reset threshold of one half, around the edge and masked-out pixels.
  task automatic test_reset_threshold();
    send_pixel(17'd0, 1'b1, 8'd0);
    send_pixel(17'd32768, 1'b1, 8'd255);
    send_pixel(17'd32769, 1'b1, 8'd128);
    send_pixel(17'd65536, 1'b1, 8'd77);
    send_pixel(17'd131071, 1'b1, 8'd1);
    send_pixel(17'd0, 1'b0, 8'd200);
    send_pixel(17'd20000, 1'b0, 8'd255);
    wait_for_results();
  endtask

  // Threshold extremes: zero, just below and at full scale, above full scale, then a small threshold.
  task automatic test_threshold_extremes();
    load_threshold(17'd0);
    send_pixel(17'd0, 1'b1, 8'd10);
    send_pixel(17'd1, 1'b1, 8'd10);
    load_threshold(17'd65535);
    send_pixel(17'd0, 1'b1, 8'd5);
    send_pixel(17'd1, 1'b1, 8'd5);
    send_pixel(17'd65535, 1'b1, 8'd5);
    send_pixel(17'd65536, 1'b1, 8'd5);
    load_threshold(17'd65536);
    send_pixel(17'd0, 1'b1, 8'd99);
    send_pixel(17'd1, 1'b1, 8'd99);
    send_pixel(17'd65536, 1'b1, 8'd99);
    send_pixel(17'd65537, 1'b1, 8'd99);
    load_threshold(17'd131071);
    send_pixel(17'd131071, 1'b1, 8'd255);
    send_pixel(17'd70000, 1'b0, 8'd3);
    send_pixel(17'd0, 1'b1, 8'd0);
    load_threshold(17'd1000);
    send_pixel(17'd500, 1'b1, 8'd77);
    send_pixel(17'd1000, 1'b1, 8'd77);
    wait_for_results();
  endtask

  // Random pixels over several thresholds and sender idle rates.
  task automatic test_random_stream();
    logic [PROB_W-1:0] thr;
    int unsigned       pct;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 7)
        0:       thr = PROB_W'($urandom_range(FULL_SCALE, 0));
        1:       thr = '0;
        2:       thr = PROB_W'(FULL_SCALE - 1);
        3:       thr = PROB_W'(FULL_SCALE);
        4:       thr = PROB_W'($urandom_range(PROB_MAX, 0));
        5:       thr = PROB_W'($urandom_range(4095, 0));
        default: thr = PROB_W'($urandom_range(FULL_SCALE - 1, 60000));
      endcase
      case (phase % 3)
        0:       pct = 0;
        1:       pct = 46;
        default: pct = 20;
      endcase
      load_threshold(thr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(pick_probability(threshold_q), ($urandom_range(99) < 85),
                   PIX_W'($urandom_range(255)));
        if ($urandom_range(59) == 0)
          wait_for_results();
        else
          idle_gap(pct);
      end
    end
    wait_for_results();
  endtask

  initial begin
    start          <= 1'b0;
    in_probability <= '0;
    in_mask_valid  <= 1'b0;
    in_gray_level  <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    rst_n          <= 1'b0;
    threshold_q    = 17'd32768;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_threshold();
    test_threshold_extremes();
    test_random_stream();

    // Let the pipeline run out, then look for anything left over.
    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_error($sformatf("%0d pixels never came back", pending_pixels.size()));
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pto_pkg.sv
rtl/pto_front.sv
rtl/pto_div_stage.sv
rtl/pto_back.sv
rtl/prob_threshold_overlay.sv
bench/tb_top.sv
